[design/pals_pkg.sv]
// ----------------------------------------------------------------------------
// pals_pkg
// Shared types and constants for the polygon axis line splitter.
// ----------------------------------------------------------------------------
package pals_pkg;

    localparam int LEAD_DEPTH = 16;
    localparam int LEAD_AW    = (LEAD_DEPTH > 1) ? $clog2(LEAD_DEPTH) : 1;
    localparam int LEAD_CW    = $clog2(LEAD_DEPTH + 1);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int COORD_W = 32;
    localparam int MAG_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int QUO_W   = PROD_W + 2;
    localparam int SUM_W   = QUO_W + 1;
    localparam int XCNT_W  = $clog2(PROD_W);

    localparam int CFG_IW  = 1;
    localparam logic [CFG_IW-1:0] REG_LINE_POSITION = 1'd0;
    localparam logic [CFG_IW-1:0] REG_SPLIT_ON_Y    = 1'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic                      final_vertex;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      low_side;
        logic                      chain_end;
        logic                      polygon_end;
        logic                      lead_overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] line_position;
        logic                      split_on_y;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    typedef enum logic {
        CMD_VERT,
        CMD_CROSS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [LEAD_CW-1:0] lead_n;
        vertex_t            vert;
        vertex_t            prev;
        logic               low;
        logic               prev_low;
        logic               fin;
        logic               ovf;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] s1;
        logic signed [COORD_W-1:0] o1;
        logic signed [COORD_W-1:0] s2;
        logic signed [COORD_W-1:0] o2;
        logic signed [COORD_W-1:0] c;
    } xing_req_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LEAD,
        B_XRUN,
        B_XEND,
        B_XBEG,
        B_VERT
    } back_state_t;

    typedef enum logic [2:0] {
        X_IDLE,
        X_MUL,
        X_DIV,
        X_FIX,
        X_SUM,
        X_SAT
    } xing_state_t;

endpackage

[design/pals_front.sv]
// ----------------------------------------------------------------------------
// pals_front
// Accepts vertices, holds leading on-line vertices, tracks the current side
// and issues one command per vertex that produces results.
// ----------------------------------------------------------------------------
module pals_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pals_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [pals_pkg::COORD_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pals_pkg::in_item_t            in_item,
    output pals_pkg::cfg_t                cfg,
    output logic                          cmd_push,
    output pals_pkg::cmd_t                cmd,
    input  logic                          cmdq_full,
    input  logic                          lead_release,
    input  logic [pals_pkg::LEAD_AW-1:0]  lead_raddr,
    output pals_pkg::vertex_t             lead_rdata
);

    logic signed [pals_pkg::COORD_W-1:0] line_reg, line_next;
    logic                                split_reg, split_next;
    logic                                lead_phase_reg, lead_phase_next;
    logic [pals_pkg::LEAD_CW-1:0]        lead_cnt_reg, lead_cnt_next;
    pals_pkg::vertex_t                   prev_reg, prev_next;
    logic                                cur_low_reg, cur_low_next;
    logic                                ovf_reg, ovf_next;
    logic                                flush_pend_reg, flush_pend_next;
    pals_pkg::vertex_t                   lead_buf_reg [pals_pkg::LEAD_DEPTH];

    logic                                accept;
    logic signed [pals_pkg::COORD_W-1:0] sig;
    logic                                on_line;
    logic                                low;
    logic                                lead_wr;
    logic                                lead_full;
    pals_pkg::vertex_t                   vert;

    assign in_stall  = cmdq_full || flush_pend_reg;
    assign accept    = in_valid && !in_stall;
    assign vert.x    = in_item.vert_x;
    assign vert.y    = in_item.vert_y;
    assign sig       = split_reg ? in_item.vert_y : in_item.vert_x;
    assign on_line   = (sig == line_reg);
    assign low       = ($signed(sig) <= $signed(line_reg));
    assign lead_full = (lead_cnt_reg >= pals_pkg::LEAD_CW'(pals_pkg::LEAD_DEPTH));
    assign lead_wr   = accept && lead_phase_reg && on_line && !lead_full;

    assign cfg.line_position = line_reg;
    assign cfg.split_on_y    = split_reg;
    assign lead_rdata        = lead_buf_reg[lead_raddr];

    always_comb
    begin
        cmd.kind     = pals_pkg::CMD_VERT;
        if (!lead_phase_reg && (low != cur_low_reg))
        begin
            cmd.kind = pals_pkg::CMD_CROSS;
        end
        cmd.lead_n   = lead_phase_reg ? lead_cnt_reg : '0;
        cmd.vert     = vert;
        cmd.prev     = prev_reg;
        cmd.low      = low;
        cmd.prev_low = cur_low_reg;
        cmd.fin      = in_item.final_vertex;
        cmd.ovf      = ovf_reg;
        cmd_push     = accept && !(lead_phase_reg && on_line);
    end

    always_comb
    begin
        line_next       = line_reg;
        split_next      = split_reg;
        lead_phase_next = lead_phase_reg;
        lead_cnt_next   = lead_cnt_reg;
        prev_next       = prev_reg;
        cur_low_next    = cur_low_reg;
        ovf_next        = ovf_reg;
        flush_pend_next = flush_pend_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                pals_pkg::REG_LINE_POSITION: line_next  = cfg_wdata;
                pals_pkg::REG_SPLIT_ON_Y:    split_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (lead_release)
        begin
            flush_pend_next = 1'b0;
        end

        if (accept)
        begin
            if (lead_phase_reg)
            begin
                if (on_line)
                begin
                    // hold on-line lead vertices; drop and flag once full
                    if (!lead_full)
                    begin
                        lead_cnt_next = lead_cnt_reg + pals_pkg::LEAD_CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_item.final_vertex)
                    begin
                        lead_cnt_next = '0;
                    end
                end
                else
                begin
                    flush_pend_next = (lead_cnt_reg != '0);
                    lead_cnt_next   = '0;
                    lead_phase_next = in_item.final_vertex;
                    cur_low_next    = low;
                    prev_next       = vert;
                end
            end
            else
            begin
                cur_low_next = low;
                prev_next    = vert;
                if (in_item.final_vertex)
                begin
                    lead_phase_next = 1'b1;
                    lead_cnt_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg       <= '0;
            split_reg      <= 1'b0;
            lead_phase_reg <= 1'b1;
            lead_cnt_reg   <= '0;
            cur_low_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            flush_pend_reg <= 1'b0;
        end
        else
        begin
            line_reg       <= line_next;
            split_reg      <= split_next;
            lead_phase_reg <= lead_phase_next;
            lead_cnt_reg   <= lead_cnt_next;
            cur_low_reg    <= cur_low_next;
            ovf_reg        <= ovf_next;
            flush_pend_reg <= flush_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        if (lead_wr)
        begin
            lead_buf_reg[lead_cnt_reg[pals_pkg::LEAD_AW-1:0]] <= vert;
        end
    end

endmodule

[design/pals_cmdq.sv]
// ----------------------------------------------------------------------------
// pals_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pals_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pals_pkg::cmd_t wdata,
    input  logic           pop,
    output pals_pkg::cmd_t rdata,
    output logic           full,
    output logic           empty
);

    pals_pkg::cmd_t                 mem_reg [pals_pkg::CMDQ_DEPTH];
    logic [pals_pkg::CMDQ_AW-1:0]   wptr_reg, wptr_next;
    logic [pals_pkg::CMDQ_AW-1:0]   rptr_reg, rptr_next;
    logic [pals_pkg::CMDQ_CW-1:0]   cnt_reg, cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (cnt_reg == pals_pkg::CMDQ_CW'(pals_pkg::CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == pals_pkg::CMDQ_AW'(pals_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : wptr_reg + pals_pkg::CMDQ_AW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == pals_pkg::CMDQ_AW'(pals_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : rptr_reg + pals_pkg::CMDQ_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + pals_pkg::CMDQ_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - pals_pkg::CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

[design/pals_xing.sv]
// ----------------------------------------------------------------------------
// pals_xing
// Crossing point unit: bit-serial multiply, restoring divide, then floor
// correction, truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module pals_xing (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  pals_pkg::xing_req_t                 req,
    output logic                                done,
    output logic signed [pals_pkg::COORD_W-1:0] result
);

    localparam int MW = pals_pkg::MAG_W;
    localparam int PW = pals_pkg::PROD_W;
    localparam int QW = pals_pkg::QUO_W;
    localparam int SW = pals_pkg::SUM_W;
    localparam int CW = pals_pkg::COORD_W;

    pals_pkg::xing_state_t           state_reg, state_next;
    logic [pals_pkg::XCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    logic signed [CW-1:0]            o1_reg, o1_next;
    logic                            neg_reg, neg_next;
    logic                            sp_reg, sp_next;
    logic                            zd_reg, zd_next;
    logic [MW-1:0]                   dm_reg, dm_next;
    logic [MW-1:0]                   ma_reg, ma_next;
    logic [PW-1:0]                   prod_reg, prod_next;
    logic [MW-1:0]                   rem_reg, rem_next;
    logic signed [QW-1:0]            q_reg, q_next;
    logic signed [SW-1:0]            f_reg, f_next;
    logic signed [CW-1:0]            res_reg, res_next;

    logic signed [MW:0]              a_w, d_w, b_w, an_w, dn_w;
    logic [MW:0]                     msum;
    logic [MW+1:0]                   trial;
    logic                            ge;
    logic [QW-1:0]                   qm;
    logic [QW-1:0]                   qbase;
    logic                            zr;
    logic signed [SW-1:0]            ft;

    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        a_w  = {{2{req.c[CW-1]}}, req.c} - {{2{req.s1[CW-1]}}, req.s1};
        d_w  = {{2{req.s2[CW-1]}}, req.s2} - {{2{req.s1[CW-1]}}, req.s1};
        b_w  = {{2{req.o2[CW-1]}}, req.o2} - {{2{req.o1[CW-1]}}, req.o1};
        an_w = d_w[MW] ? -a_w : a_w;
        dn_w = d_w[MW] ? -d_w : d_w;
    end

    always_comb
    begin
        msum  = {1'b0, prod_reg[PW-1:MW]} + (prod_reg[0] ? {1'b0, ma_reg} : '0);
        trial = {1'b0, rem_reg, prod_reg[PW-1]} - {2'b00, dm_reg};
        ge    = !trial[MW+1];
        qm    = {2'b00, prod_reg};
        zr    = (rem_reg == '0);
        qbase = sp_reg ? ~qm : qm;
        ft    = f_reg[SW-1] ? f_reg + SW'(1) : f_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        o1_next    = o1_reg;
        neg_next   = neg_reg;
        sp_next    = sp_reg;
        zd_next    = zd_reg;
        dm_next    = dm_reg;
        ma_next    = ma_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        f_next     = f_reg;
        res_next   = res_reg;

        case (state_reg)
            pals_pkg::X_IDLE:
            begin
                if (start)
                begin
                    o1_next   = req.o1;
                    neg_next  = d_w[MW];
                    sp_next   = an_w[MW] ^ b_w[MW];
                    zd_next   = (d_w == '0);
                    dm_next   = dn_w[MW-1:0];
                    ma_next   = an_w[MW] ? MW'(-an_w) : an_w[MW-1:0];
                    prod_next = {{MW{1'b0}}, (b_w[MW] ? MW'(-b_w) : b_w[MW-1:0])};
                    rem_next  = '0;
                    cnt_next  = pals_pkg::XCNT_W'(MW - 1);
                    state_next = (d_w == '0) ? pals_pkg::X_FIX : pals_pkg::X_MUL;
                end
            end
            pals_pkg::X_MUL:
            begin
                prod_next = {msum, prod_reg[MW-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next   = pals_pkg::XCNT_W'(PW - 1);
                    state_next = pals_pkg::X_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - pals_pkg::XCNT_W'(1);
                end
            end
            pals_pkg::X_DIV:
            begin
                prod_next = {prod_reg[PW-2:0], ge};
                rem_next  = ge ? trial[MW-1:0] : {rem_reg[MW-2:0], prod_reg[PW-1]};
                if (cnt_reg == '0)
                begin
                    state_next = pals_pkg::X_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - pals_pkg::XCNT_W'(1);
                end
            end
            pals_pkg::X_FIX:
            begin
                // floor of the signed quotient, then one lower on a negative
                // divisor with exact division
                if (zr && sp_reg && !neg_reg)
                begin
                    q_next = $signed(qbase) + QW'(1);
                end
                else if (zr && neg_reg && !sp_reg)
                begin
                    q_next = $signed(qbase) - QW'(1);
                end
                else
                begin
                    q_next = $signed(qbase);
                end
                state_next = pals_pkg::X_SUM;
            end
            pals_pkg::X_SUM:
            begin
                f_next     = {{(SW-CW){o1_reg[CW-1]}}, o1_reg} + {q_reg[QW-1], q_reg};
                state_next = pals_pkg::X_SAT;
            end
            pals_pkg::X_SAT:
            begin
                if (zd_reg)
                begin
                    res_next = o1_reg;
                end
                else if (ft > $signed({{(SW-CW){1'b0}}, 1'b0, {(CW-1){1'b1}}}))
                begin
                    res_next = {1'b0, {(CW-1){1'b1}}};
                end
                else if (ft < $signed({{(SW-CW){1'b1}}, 1'b1, {(CW-1){1'b0}}}))
                begin
                    res_next = {1'b1, {(CW-1){1'b0}}};
                end
                else
                begin
                    res_next = ft[CW-1:0];
                end
                done_next  = 1'b1;
                state_next = pals_pkg::X_IDLE;
            end
            default:
            begin
                state_next = pals_pkg::X_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pals_pkg::X_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        o1_reg   <= o1_next;
        neg_reg  <= neg_next;
        sp_reg   <= sp_next;
        zd_reg   <= zd_next;
        dm_reg   <= dm_next;
        ma_reg   <= ma_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        f_reg    <= f_next;
        res_reg  <= res_next;
    end

endmodule

[design/pals_back.sv]
// ----------------------------------------------------------------------------
// pals_back
// Carries out commands: replays held lead vertices, runs crossings and
// drives the output register.
// ----------------------------------------------------------------------------
module pals_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pals_pkg::cfg_t                      cfg,
    input  pals_pkg::cmd_t                      cmd,
    input  logic                                cmdq_empty,
    output logic                                cmd_pop,
    output logic [pals_pkg::LEAD_AW-1:0]        lead_raddr,
    input  pals_pkg::vertex_t                   lead_rdata,
    output logic                                lead_release,
    output logic                                x_start,
    output pals_pkg::xing_req_t                 x_req,
    input  logic                                x_done,
    input  logic signed [pals_pkg::COORD_W-1:0] x_result,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pals_pkg::out_item_t                 out_item
);

    pals_pkg::back_state_t         state_reg, state_next;
    pals_pkg::cmd_t                cmd_reg;
    logic [pals_pkg::LEAD_CW-1:0]  idx_reg;
    logic                          out_valid_reg;
    pals_pkg::out_item_t           out_item_reg;

    logic                          can_load;
    logic                          load;
    logic                          lead_last;
    pals_pkg::out_item_t           out_item_next;
    pals_pkg::vertex_t             xpt;

    assign can_load   = !out_valid_reg || !out_stall;
    assign lead_raddr = idx_reg[pals_pkg::LEAD_AW-1:0];
    assign lead_last  = (idx_reg == cmd_reg.lead_n - pals_pkg::LEAD_CW'(1));
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;
    assign xpt.x      = cfg.split_on_y ? x_result : cfg.line_position;
    assign xpt.y      = cfg.split_on_y ? cfg.line_position : x_result;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pals_pkg::B_IDLE:
            begin
                if (!cmdq_empty)
                begin
                    if (cmd.kind == pals_pkg::CMD_CROSS)
                    begin
                        state_next = pals_pkg::B_XRUN;
                    end
                    else if (cmd.lead_n != '0)
                    begin
                        state_next = pals_pkg::B_LEAD;
                    end
                    else
                    begin
                        state_next = pals_pkg::B_VERT;
                    end
                end
            end
            pals_pkg::B_LEAD:
            begin
                if (can_load && lead_last)
                begin
                    state_next = pals_pkg::B_VERT;
                end
            end
            pals_pkg::B_XRUN:
            begin
                if (x_done)
                begin
                    state_next = pals_pkg::B_XEND;
                end
            end
            pals_pkg::B_XEND:
            begin
                if (can_load)
                begin
                    state_next = pals_pkg::B_XBEG;
                end
            end
            pals_pkg::B_XBEG:
            begin
                if (can_load)
                begin
                    state_next = pals_pkg::B_VERT;
                end
            end
            pals_pkg::B_VERT:
            begin
                if (can_load)
                begin
                    state_next = pals_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = pals_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop       = (state_reg == pals_pkg::B_IDLE) && !cmdq_empty;
        x_start       = cmd_pop && (cmd.kind == pals_pkg::CMD_CROSS);
        x_req.c       = cfg.line_position;
        x_req.s1      = cfg.split_on_y ? cmd.prev.y : cmd.prev.x;
        x_req.o1      = cfg.split_on_y ? cmd.prev.x : cmd.prev.y;
        x_req.s2      = cfg.split_on_y ? cmd.vert.y : cmd.vert.x;
        x_req.o2      = cfg.split_on_y ? cmd.vert.x : cmd.vert.y;
        lead_release  = 1'b0;
        load          = 1'b0;

        out_item_next.out_x         = cmd_reg.vert.x;
        out_item_next.out_y         = cmd_reg.vert.y;
        out_item_next.low_side      = cmd_reg.low;
        out_item_next.chain_end     = 1'b0;
        out_item_next.polygon_end   = 1'b0;
        out_item_next.lead_overflow = cmd_reg.ovf;

        case (state_reg)
            pals_pkg::B_LEAD:
            begin
                load                = can_load;
                lead_release        = can_load && lead_last;
                out_item_next.out_x = lead_rdata.x;
                out_item_next.out_y = lead_rdata.y;
            end
            pals_pkg::B_XEND:
            begin
                // close the old chain at the crossing point
                load                    = can_load;
                out_item_next.out_x     = xpt.x;
                out_item_next.out_y     = xpt.y;
                out_item_next.low_side  = cmd_reg.prev_low;
                out_item_next.chain_end = 1'b1;
            end
            pals_pkg::B_XBEG:
            begin
                load                = can_load;
                out_item_next.out_x = xpt.x;
                out_item_next.out_y = xpt.y;
            end
            pals_pkg::B_VERT:
            begin
                load                      = can_load;
                out_item_next.chain_end   = cmd_reg.fin;
                out_item_next.polygon_end = cmd_reg.fin;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pals_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
            idx_reg <= '0;
        end
        else if ((state_reg == pals_pkg::B_LEAD) && can_load)
        begin
            idx_reg <= idx_reg + pals_pkg::LEAD_CW'(1);
        end
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

[design/polygon_axis_line_splitter_top.sv]
// ----------------------------------------------------------------------------
// polygon_axis_line_splitter_top
// Splits a stream of polygon vertices into chains on either side of an
// axis-aligned line.
// ----------------------------------------------------------------------------
// A vertex that stays on its side passes the back end's idle and vertex
// states. A vertex that crosses the line is issued, then takes 33 multiply
// steps, 66 divide steps and 3 correction steps in the crossing unit; the
// result is handed back and the vertex emits its three items. Leading
// on-line vertices are buffered in the front end (up to 16) and replayed at
// one item per cycle, while the output is not stalled, before the first off-line vertex.
// While that replay runs the input is stalled. The front end takes a new
// vertex each cycle while the 2-entry command queue has room, so short runs
// of vertices overlap a slow crossing.
module polygon_axis_line_splitter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pals_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [pals_pkg::COORD_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pals_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pals_pkg::out_item_t           out_item
);

    pals_pkg::cfg_t                      cfg;
    pals_pkg::cmd_t                      push_cmd;
    pals_pkg::cmd_t                      head_cmd;
    logic                                cmd_push;
    logic                                cmd_pop;
    logic                                cmdq_full;
    logic                                cmdq_empty;
    logic                                lead_release;
    logic [pals_pkg::LEAD_AW-1:0]        lead_raddr;
    pals_pkg::vertex_t                   lead_rdata;
    logic                                x_start;
    pals_pkg::xing_req_t                 x_req;
    logic                                x_done;
    logic signed [pals_pkg::COORD_W-1:0] x_result;

    pals_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .cfg          (cfg),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd),
        .cmdq_full    (cmdq_full),
        .lead_release (lead_release),
        .lead_raddr   (lead_raddr),
        .lead_rdata   (lead_rdata)
    );

    pals_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (push_cmd),
        .pop   (cmd_pop),
        .rdata (head_cmd),
        .full  (cmdq_full),
        .empty (cmdq_empty)
    );

    pals_xing u_xing (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (x_start),
        .req    (x_req),
        .done   (x_done),
        .result (x_result)
    );

    pals_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (head_cmd),
        .cmdq_empty   (cmdq_empty),
        .cmd_pop      (cmd_pop),
        .lead_raddr   (lead_raddr),
        .lead_rdata   (lead_rdata),
        .lead_release (lead_release),
        .x_start      (x_start),
        .x_req        (x_req),
        .x_done       (x_done),
        .x_result     (x_result),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

endmodule

[design/pals_checker.sv]
// ----------------------------------------------------------------------------
// pals_checker
// Port-level checks for the polygon axis line splitter.
// ----------------------------------------------------------------------------
module pals_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input pals_pkg::out_item_t out_item
);

    logic ovf_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && out_item.lead_overflow)
        begin
            ovf_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("out_item changed while stalled");

    a_pend_cend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.polygon_end |-> out_item.chain_end)
        else $error("polygon end without chain end");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ovf_seen_reg |-> out_item.lead_overflow)
        else $error("lead overflow flag cleared");

endmodule

bind polygon_axis_line_splitter_top pals_checker u_pals_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the polygon axis line splitter. Sends polygon vertices
// through the valid/stall channel and checks every chain vertex against
// a behavioral predictor of the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [pals_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [pals_pkg::COORD_W-1:0]  cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    pals_pkg::in_item_t            in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    pals_pkg::out_item_t           out_item;

    // Predictor state
    logic signed [31:0]   lead_xs [pals_pkg::LEAD_DEPTH];
    logic signed [31:0]   lead_ys [pals_pkg::LEAD_DEPTH];
    int                   lead_n = 0;
    bit                   leading = 1'b1;
    logic signed [31:0]   last_x = 0, last_y = 0;
    bit                   side_low = 1'b0;
    bit                   overflow_flag = 1'b0;
    logic signed [31:0]   line_pos = 0;
    bit                   on_y = 1'b0;

    pals_pkg::out_item_t  chain_queue[$];
    int                   errors = 0;
    bit                   quiet_stretch = 1'b0;
    int                   idle_cycles = 0;

    always #1 clk = ~clk;

    polygon_axis_line_splitter_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    function automatic logic signed [31:0] cross_point(longint s1, longint o1, longint s2,
                                                       longint o2, longint c);
        logic signed [127:0] num, den, q, f;
        den = s2 - s1;
        if (den == 0)
            return o1[31:0];
        // value = o1 + (num + 1/2)/den  = o1 + (2num + 1)/(2den)
        num = 2 * ((c - s1) * (o2 - o1)) + 1;
        den = 2 * den;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        q = num / den;
        if ((num % den) < 0)
            q = q - 1;
        f = o1 + q;
        // value is never an integer, so floor+1 truncates negatives
        if (f < 0)
            f = f + 1;
        if (f > 128'sd2147483647)
            f = 128'sd2147483647;
        if (f < -128'sd2147483648)
            f = -128'sd2147483648;
        return f[31:0];
    endfunction

    function automatic void add_chain(logic signed [31:0] x, logic signed [31:0] y,
                                      bit low, bit cend, bit pend);
        pals_pkg::out_item_t r;
        r.out_x = x;
        r.out_y = y;
        r.low_side = low;
        r.chain_end = cend;
        r.polygon_end = pend;
        r.lead_overflow = overflow_flag;
        chain_queue = {chain_queue, r};
    endfunction

    function automatic void predict_split(pals_pkg::in_item_t v);
        logic signed [31:0] s, cx, cy;
        bit low;
        s = on_y ? v.vert_y : v.vert_x;
        low = (s <= line_pos);
        if (leading)
        begin
            if (s == line_pos)
            begin
                if (lead_n < pals_pkg::LEAD_DEPTH)
                begin
                    lead_xs[lead_n] = v.vert_x;
                    lead_ys[lead_n] = v.vert_y;
                    lead_n++;
                end
                else
                    overflow_flag = 1'b1;
                if (v.final_vertex)
                    lead_n = 0;
                return;
            end
            for (int i = 0; i < lead_n; i++)
                add_chain(lead_xs[i], lead_ys[i], low, 1'b0, 1'b0);
            add_chain(v.vert_x, v.vert_y, low, v.final_vertex, v.final_vertex);
            lead_n = 0;
            leading = v.final_vertex;
            side_low = low;
            last_x = v.vert_x;
            last_y = v.vert_y;
            return;
        end
        if (low == side_low)
            add_chain(v.vert_x, v.vert_y, low, v.final_vertex, v.final_vertex);
        else
        begin
            if (on_y)
            begin
                cx = cross_point(last_y, last_x, v.vert_y, v.vert_x, line_pos);
                cy = line_pos;
            end
            else
            begin
                cx = line_pos;
                cy = cross_point(last_x, last_y, v.vert_x, v.vert_y, line_pos);
            end
            add_chain(cx, cy, side_low, 1'b1, 1'b0);
            add_chain(cx, cy, low, 1'b0, 1'b0);
            add_chain(v.vert_x, v.vert_y, low, v.final_vertex, v.final_vertex);
            side_low = low;
        end
        last_x = v.vert_x;
        last_y = v.vert_y;
        if (v.final_vertex)
        begin
            leading = 1'b1;
            lead_n = 0;
        end
    endfunction

    function automatic bit take_break();
        return !quiet_stretch && ($urandom_range(99) < 31);
    endfunction

    // Send one vertex; valid may idle before it, but holds once raised.
    // Valid stays high after the accept so the next item can follow at once.
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, bit fin);
        pals_pkg::in_item_t v;
        v.vert_x = x;
        v.vert_y = y;
        v.final_vertex = fin;
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_split(v);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (chain_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [pals_pkg::CFG_IW-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == pals_pkg::REG_LINE_POSITION)
            line_pos = val;
        else
            on_y = val[0];
    endtask

    task automatic set_line(logic signed [31:0] pos, bit y_axis);
        wait_idle();
        write_reg(pals_pkg::REG_LINE_POSITION, pos);
        write_reg(pals_pkg::REG_SPLIT_ON_Y, {31'd0, y_axis});
        cfg_wr_en <= 1'b0;
    endtask

    // Random coordinate: often on or near the line, sometimes at the extremes.
    function automatic logic signed [31:0] rand_coord(logic signed [31:0] base);
        case ($urandom_range(5))
            0: return $urandom;
            1: return base;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return base + $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    task automatic send_on_axis(logic signed [31:0] s, logic signed [31:0] o, bit fin);
        if (on_y)
            send_vertex(o, s, fin);
        else
            send_vertex(s, o, fin);
    endtask

    task automatic test_basic_crossings();
        set_line(0, 1'b0);
        send_vertex(-10, -10, 0);
        send_vertex(10, -10, 0);
        send_vertex(10, 10, 0);
        send_vertex(-10, 10, 0);
        send_vertex(-10, -10, 1);
        set_line(5, 1'b1);
        send_vertex(0, 0, 0);
        send_vertex(3, 7, 0);
        send_vertex(-4, 2, 1);
    endtask

    task automatic test_extremes();
        set_line(32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1);
        set_line(32'h8000_0000, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1);
        set_line(0, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1);
    endtask

    task automatic test_lead_and_all_on_line();
        set_line(3, 1'b0);
        send_vertex(3, 1, 0);
        send_vertex(3, 2, 0);
        send_vertex(3, 3, 1);
        send_vertex(3, -5, 0);
        send_vertex(3, 9, 0);
        send_vertex(8, 0, 0);
        send_vertex(-2, 4, 1);
    endtask

    task automatic test_lead_overflow();
        for (int i = 0; i < pals_pkg::LEAD_DEPTH + 2; i++)
            send_vertex(3, i, 0);
        send_vertex(-1, 0, 1);
    endtask

    task automatic test_random_polygons();
        int sent;
        int len;
        logic signed [31:0] base;
        sent = 0;
        while (sent < 60)
        begin
            base = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2000)) - 1000;
            set_line(base, 1'($urandom_range(1)));
            len = $urandom_range(2, 7);
            if ($urandom_range(9) == 0)
                len = $urandom_range(18, 20);
            for (int i = 0; i < len; i++)
            begin
                if (len > 10 && i < len - 2)
                    send_on_axis(base, $urandom, 0);
                else
                    send_on_axis(rand_coord(base), $urandom, (i == len - 1) ||
                                 ($urandom_range(19) == 0));
                sent++;
            end
        end
    endtask

    // Result checker and receiver idling
    always @(posedge clk)
    begin
        pals_pkg::out_item_t exp_item;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (chain_queue.size() == 0)
                begin
                    $display("%t unexpected item: expected none, got %p", $realtime, out_item);
                    errors++;
                end
                else
                begin
                    exp_item = chain_queue[0];
                    chain_queue.delete(0);
                    if (out_item !== exp_item)
                    begin
                        $display("%t mismatch: expected %p, got %p",
                                 $realtime, exp_item, out_item);
                        errors++;
                    end
                end
            end
            out_stall <= take_break();
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[polygon_axis_line_splitter_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_crossings();
        test_extremes();
        test_lead_and_all_on_line();
        test_lead_overflow();
        test_random_polygons();
        quiet_stretch = 1'b1;
        set_line(-7, 1'b1);
        for (int i = 0; i < 12; i++)
            send_vertex($urandom, $signed($urandom_range(20)) - 17, i == 11);
        wait_idle();
        if (errors == 0)
            $display("[polygon_axis_line_splitter_top] OK");
        else
            $display("[polygon_axis_line_splitter_top] ERROR");
        $finish;
    end

endmodule

[polygon_axis_line_splitter_top.f]
design/pals_pkg.sv
design/pals_front.sv
design/pals_cmdq.sv
design/pals_xing.sv
design/pals_back.sv
design/polygon_axis_line_splitter_top.sv
design/pals_checker.sv
tb/tb.sv
